/* rtl/masked_softmax_row_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the masked softmax row core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_SOFTMAX_ROW_CORE_MACROS_SVH
`define MASKED_SOFTMAX_ROW_CORE_MACROS_SVH

// same-cycle implication
`define MSR_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("implication check failed");

// next-cycle implication
`define MSR_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("next-cycle check failed");

`endif

/* rtl/msr_pkg.sv */
// ----------------------------------------------------------------------------
// msr_pkg
// Types, constants and the exponential table builder for the softmax core.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int unsigned    MAX_TABLE_BITS = 12;
    localparam int unsigned    SUM_W          = 23;
    localparam int unsigned    TERM_W         = 17;
    localparam int unsigned    QUO_W          = 33;
    localparam logic [15:0]    LOG2E_Q15      = 16'd47274;
    localparam logic [63:0]    LN2_Q32        = 64'd2977044472;

    typedef logic [TERM_W-1:0] exp_rom_t [1 << MAX_TABLE_BITS];

    typedef struct packed {
        logic in_ready;
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic rd;
        logic stage_t;
        logic stage_term;
        logic acc;
        logic div_start;
        logic div_step;
        logic stage_prod;
        logic emit;
        logic row_clear;
    } msr_cmd_t;

    typedef struct packed {
        logic last_idx;
        logic seen;
        logic div_done;
        logic out_free;
    } msr_status_t;

    // 65536 * exp(-k*ln2/2^bits), Taylor series in Q32.32
    function automatic exp_rom_t build_exp_rom(int unsigned bits);
        exp_rom_t    rom;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        rom = '{default: '0};
        for (int unsigned k = 0; k < (1 << bits); k++)
        begin
            y    = (64'(k) * LN2_Q32) >> bits;
            term = 64'd1 << 32;
            sum  = term;
            for (int unsigned n = 1; n <= 14; n++)
            begin
                term = ((term * y) >> 32) / 64'(n);
                if (n[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            r = (sum + 64'd32768) >> 16;
            if (r > 64'd65536)
                r = 64'd65536;
            rom[k] = r[TERM_W-1:0];
        end
        return rom;
    endfunction

endpackage

/* rtl/msr_in_if.sv */
// ----------------------------------------------------------------------------
// msr_in_if
// Input channel: one row element per transaction.
// ----------------------------------------------------------------------------
interface msr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] score;
    logic               masked;
    logic               row_end;

    modport source (output valid, output score, output masked, output row_end, input ready);
    modport sink   (input valid, input score, input masked, input row_end, output ready);
endinterface

/* rtl/msr_out_if.sv */
// ----------------------------------------------------------------------------
// msr_out_if
// Output channel: one probability per transaction.
// ----------------------------------------------------------------------------
interface msr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] prob;
    logic        final_out;
    logic        all_masked;
    logic        overflowed;

    modport source (output valid, output prob, output final_out, output all_masked,
                    output overflowed, input ready);
    modport sink   (input valid, input prob, input final_out, input all_masked,
                    input overflowed, output ready);
endinterface

/* rtl/msr_ram.sv */
// ----------------------------------------------------------------------------
// msr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/msr_ctrl.sv */
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer: load, sum pass, reciprocal, output pass.
// ----------------------------------------------------------------------------
module msr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_row_end,
    input  msr_pkg::msr_status_t status,
    output msr_pkg::msr_cmd_t    cmd
);
    import msr_pkg::*;

    typedef enum logic [3:0] {
        LOAD, S_RD, S_DAT, S_TRM, S_ACC, DIV,
        O_RD, O_DAT, O_TRM, O_MUL, O_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            LOAD:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_row_end)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DAT;
            end
            S_DAT:
            begin
                cmd.stage_t = 1'b1;
                state_next  = S_TRM;
            end
            S_TRM:
            begin
                cmd.stage_term = 1'b1;
                state_next     = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.last_idx)
                begin
                    cmd.idx_clr   = 1'b1;
                    cmd.div_start = status.seen;
                    state_next    = status.seen ? DIV : O_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            DIV:
            begin
                if (status.div_done)
                    state_next = O_RD;
                else
                    cmd.div_step = 1'b1;
            end
            O_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = O_DAT;
            end
            O_DAT:
            begin
                cmd.stage_t = 1'b1;
                state_next  = O_TRM;
            end
            O_TRM:
            begin
                cmd.stage_term = 1'b1;
                state_next     = O_MUL;
            end
            O_MUL:
            begin
                cmd.stage_prod = 1'b1;
                state_next     = O_EMIT;
            end
            O_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_idx)
                    begin
                        cmd.row_clear = 1'b1;
                        state_next    = LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = O_RD;
                    end
                end
            end
            default: state_next = LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LOAD;
        else
            state_reg <= state_next;
    end
endmodule

/* rtl/msr_datapath.sv */
// ----------------------------------------------------------------------------
// msr_datapath
// Row store, running max, exponential unit, sum, divider, output register.
// ----------------------------------------------------------------------------
module msr_datapath #(
    parameter int ROW_LEN        = 64,
    parameter int SCORE_WIDTH    = 16,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msr_pkg::msr_cmd_t     cmd,
    output msr_pkg::msr_status_t  status,
    input  logic signed [15:0]   in_score,
    input  logic                 in_masked,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_prob,
    output logic                 out_final,
    output logic                 out_all_masked,
    output logic                 out_overflowed
);
    import msr_pkg::*;

    localparam int SW = SCORE_WIDTH;
    localparam int IW = (SW > 16) ? SW : 16;
    localparam int AW = $clog2(ROW_LEN);
    localparam int CW = $clog2(ROW_LEN + 1);
    localparam int TW = SW + 17;
    localparam int NW = TW - 23;
    localparam int B  = EXP_TABLE_BITS;
    localparam exp_rom_t EXP_ROM = build_exp_rom(B);

    logic [CW-1:0]        fill_reg;
    logic signed [SW-1:0] max_reg;
    logic                 seen_reg, drop_reg;
    logic [AW-1:0]        idx_reg;
    logic [TW-1:0]        t_reg;
    logic                 mask_reg;
    logic [TERM_W-1:0]    term_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W:0]       rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [5:0]           div_cnt_reg;
    logic [2*TERM_W-1:0]  prod_reg;

    logic [IW-1:0]        score_wide;
    logic signed [SW-1:0] x_in;
    logic                 store_ok;
    logic [SW:0]          rd_data;
    logic signed [SW:0]   diff;
    logic [NW-1:0]        n_hi;
    logic [B-1:0]         k_idx;
    logic [TERM_W-1:0]    rom_val;
    logic [SUM_W:0]       trial;
    logic [2*TERM_W:0]    rounded;
    logic [2*TERM_W-16:0] scaled;
    logic [15:0]          prob_sat;

    assign score_wide = IW'($unsigned(in_score));
    assign x_in       = signed'(score_wide[SW-1:0]);
    assign store_ok   = fill_reg < CW'(ROW_LEN);

    msr_ram #(.WIDTH(SW + 1), .DEPTH(ROW_LEN)) u_store (
        .clk     (clk),
        .wr_en   (cmd.load && store_ok),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data ({in_masked, x_in}),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // store word is {mask, score}; sign-extend the score part only
    assign diff    = {max_reg[SW-1], max_reg} - {rd_data[SW-1], rd_data[SW-1:0]};
    assign n_hi    = t_reg[TW-1:23];
    assign k_idx   = t_reg[22 -: B];
    assign rom_val = EXP_ROM[MAX_TABLE_BITS'(k_idx)];
    assign trial   = {rem_reg[SUM_W-1:0], (div_cnt_reg == 6'd0)};
    assign rounded = {1'b0, prod_reg} + (2*TERM_W+1)'(32768);
    assign scaled  = rounded[2*TERM_W:16];
    assign prob_sat = (scaled > (2*TERM_W-15)'(65535)) ? 16'hFFFF : scaled[15:0];

    assign status.last_idx = (CW'(idx_reg) + CW'(1)) == fill_reg;
    assign status.seen     = seen_reg;
    assign status.div_done = div_cnt_reg == 6'(QUO_W);
    assign status.out_free = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            max_reg   <= '0;
            seen_reg  <= 1'b0;
            drop_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (store_ok)
                begin
                    fill_reg <= fill_reg + CW'(1);
                    if (!in_masked)
                    begin
                        if (!seen_reg || x_in > max_reg)
                            max_reg <= x_in;
                        seen_reg <= 1'b1;
                    end
                end
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.row_clear)
            begin
                fill_reg <= '0;
                max_reg  <= '0;
                seen_reg <= 1'b0;
                drop_reg <= 1'b0;
            end
            if (cmd.emit)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + AW'(1);

        if (cmd.stage_t)
        begin
            t_reg    <= TW'($unsigned(diff)) * TW'(LOG2E_Q15);
            mask_reg <= rd_data[SW];
        end

        if (cmd.stage_term)
        begin
            if (32'(n_hi) >= 32'd17)
                term_reg <= '0;
            else
                term_reg <= rom_val >> n_hi[4:0];
        end

        if (cmd.load && cmd.idx_clr)
            sum_reg <= '0;
        else if (cmd.acc && seen_reg && !mask_reg)
            sum_reg <= sum_reg + SUM_W'(term_reg);

        if (cmd.div_start)
        begin
            rem_reg     <= '0;
            quo_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (trial >= {1'b0, sum_reg})
            begin
                rem_reg <= trial - {1'b0, sum_reg};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end

        if (cmd.stage_prod)
            prod_reg <= (2*TERM_W)'(term_reg) * (2*TERM_W)'(quo_reg[TERM_W-1:0]);

        if (cmd.emit)
        begin
            out_prob       <= (seen_reg && !mask_reg) ? prob_sat : 16'd0;
            out_final      <= status.last_idx;
            out_all_masked <= !seen_reg;
            out_overflowed <= drop_reg;
        end
    end
endmodule

/* rtl/masked_softmax_row_core.sv */
// ----------------------------------------------------------------------------
// masked_softmax_row_core
// Masked softmax over one row of Q8.8 scores, Q0.16 probabilities out.
// ----------------------------------------------------------------------------
// in_ch: one score with its mask bit per transaction; row_end closes the row.
//   Elements beyond ROW_LEN are dropped and the row is flagged overflowed.
// out_ch: one probability per stored element, in order, final_out on the
//   last; a fully masked row gives zeros with all_masked set.
// Loading accepts one element per cycle. After row_end the block is busy:
//   a sum pass of four steps per element (store read, exponent multiply,
//   table lookup, accumulate), a bit-serial reciprocal (skipped for a
//   fully masked row), then an output pass per element (store read,
//   exponent multiply, table lookup, multiply, emit), paced by the single
//   store read port and the shared exp unit.
// in_ch.ready is high only while loading a row.
// Reset clears the fill counter, the row flags and the output valid; store contents are
//   not cleared, as only entries of the current row are read.
// A stalled receiver holds the output register and stops the output pass.
// ----------------------------------------------------------------------------
module masked_softmax_row_core #(
    parameter int ROW_LEN        = 64,
    parameter int SCORE_WIDTH    = 16,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    msr_in_if.sink    in_ch,
    msr_out_if.source out_ch
);
    import msr_pkg::*;

    msr_cmd_t    cmd;
    msr_status_t status;

    assign in_ch.ready = cmd.in_ready;

    msr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_row_end (in_ch.row_end),
        .status     (status),
        .cmd        (cmd)
    );

    msr_datapath #(
        .ROW_LEN        (ROW_LEN),
        .SCORE_WIDTH    (SCORE_WIDTH),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_score       (in_ch.score),
        .in_masked      (in_ch.masked),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_prob       (out_ch.prob),
        .out_final      (out_ch.final_out),
        .out_all_masked (out_ch.all_masked),
        .out_overflowed (out_ch.overflowed)
    );
endmodule

/* rtl/msr_checker.sv */
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks on the softmax core, bound to the top level.
// ----------------------------------------------------------------------------
`include "masked_softmax_row_core_macros.svh"

module msr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_row_end,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_prob,
    input logic        out_all_masked
);
    // stalled output transaction holds
    `MSR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_prob))
    // fully masked rows give zero probability
    `MSR_ASSERT_IMP(a_masked_zero, clk, rst_n, out_valid && out_all_masked, out_prob == 16'd0)
    // closing a row makes the block busy
    `MSR_ASSERT_NXT(a_busy_after_end, clk, rst_n, in_valid && in_ready && in_row_end, !in_ready)
    // no output is produced while a row is still being loaded from empty
    `MSR_ASSERT_NXT(a_no_new_out, clk, rst_n, in_ready && !out_valid, !out_valid)
endmodule

bind masked_softmax_row_core msr_checker u_msr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_row_end     (in_ch.row_end),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_prob       (out_ch.prob),
    .out_all_masked (out_ch.all_masked)
);

/* tb/masked_softmax_row_core_test.sv */
// ----------------------------------------------------------------------------
// masked_softmax_row_core_test
// Self-checking bench for the masked softmax row core. Rows of scores go in
// on the input channel with random idle bursts. A local predictor works out
// every probability and flag, and each output transaction is compared with
// the oldest expected result. Directed rows cover the extremes, masking,
// fully masked rows and overlong rows; random rows follow.
// ----------------------------------------------------------------------------
module masked_softmax_row_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LEN = 64;
    localparam int TBL_BITS = 8;

    typedef struct {
        logic [15:0] prob;
        logic        fin;
        logic        allm;
        logic        ovf;
    } prob_rec_t;

    logic clk;
    logic rst_n;

    msr_in_if  in_ch();
    msr_out_if out_ch();

    masked_softmax_row_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    prob_rec_t         probs_due[$];
    longint unsigned   exp_lut[1 << TBL_BITS];
    logic signed [15:0] row_score[ROW_LEN];
    logic              row_mask[ROW_LEN];
    int                row_fill;
    logic signed [15:0] row_max;
    logic              row_seen;
    logic              row_drop;
    bit                quiet;
    int                n_err;
    int                n_items;
    int                n_rows;
    int                n_results;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("** masked_softmax_row_core: FAILED **");
        $finish;
    end

    function automatic void build_lut();
        longint unsigned y;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned r;
        for (int k = 0; k < (1 << TBL_BITS); k++)
        begin
            y    = (longint'(k) * 64'd2977044472) >> TBL_BITS;
            term = 64'd1 << 32;
            acc  = term;
            for (int n = 1; n <= 14; n++)
            begin
                term = ((term * y) >> 32) / longint'(n);
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            r = (acc + 64'd32768) >> 16;
            if (r > 64'd65536)
                r = 64'd65536;
            exp_lut[k] = r;
        end
    endfunction

    function automatic longint unsigned exp_weight(longint d);
        longint unsigned t;
        longint unsigned sh;
        t  = longint'(d) * 64'd47274;
        sh = t >> 23;
        if (sh >= 17)
            return 0;
        return exp_lut[(t >> 15) & 64'hFF] >> sh;
    endfunction

    function automatic void predict_row();
        longint unsigned total;
        longint unsigned recip;
        longint unsigned p;
        prob_rec_t       rec;
        total = 0;
        recip = 0;
        if (row_seen)
        begin
            for (int k = 0; k < row_fill; k++)
                if (!row_mask[k])
                    total += exp_weight(longint'(row_max) - longint'(row_score[k]));
            if (total != 0)
                recip = (64'd1 << 32) / total;
        end
        for (int k = 0; k < row_fill; k++)
        begin
            p = 0;
            if (row_seen && !row_mask[k])
            begin
                p = (exp_weight(longint'(row_max) - longint'(row_score[k])) * recip
                     + 64'd32768) >> 16;
                if (p > 65535)
                    p = 65535;
            end
            rec.prob = p[15:0];
            rec.fin  = (k + 1 == row_fill);
            rec.allm = !row_seen;
            rec.ovf  = row_drop;
            probs_due.push_back(rec);
        end
        row_fill = 0;
        row_max  = '0;
        row_seen = 1'b0;
        row_drop = 1'b0;
        n_rows++;
    endfunction

    task automatic send_item(logic signed [15:0] s, logic m, logic e);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.score   <= s;
        in_ch.masked  <= m;
        in_ch.row_end <= e;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_items++;
        if (row_fill < ROW_LEN)
        begin
            row_score[row_fill] = s;
            row_mask[row_fill]  = m;
            row_fill++;
            if (!m)
            begin
                if (!row_seen || s > row_max)
                    row_max = s;
                row_seen = 1'b1;
            end
        end
        else
            row_drop = 1'b1;
        if (e)
            predict_row();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (probs_due.size() != 0)
            @(posedge clk);
    endtask

    // output side: random stalls plus result comparison
    initial
    begin
        int stall;
        prob_rec_t want;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                n_results++;
                if (probs_due.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected transaction prob=%0d", out_ch.prob);
                end
                else
                begin
                    want = probs_due.pop_front();
                    if (out_ch.prob !== want.prob || out_ch.final_out !== want.fin
                        || out_ch.all_masked !== want.allm
                        || out_ch.overflowed !== want.ovf)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp p=%0d f=%b a=%b o=%b, %s%0d f=%b a=%b o=%b",
                                     want.prob, want.fin, want.allm, want.ovf, "got p=",
                                     out_ch.prob, out_ch.final_out, out_ch.all_masked,
                                     out_ch.overflowed);
                    end
                end
            end
            if (stall > 0)
                stall--;
            else if (!quiet && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 7);
            out_ch.ready <= (stall == 0);
        end
    end

    task automatic test_basic_rows();
        send_item(16'sd100, 1'b0, 1'b1);
        send_item(16'sh7FFF, 1'b0, 1'b0);
        send_item(-16'sd32768, 1'b0, 1'b0);
        send_item(16'sh7FFF, 1'b1, 1'b0);
        send_item(16'sd0, 1'b0, 1'b1);
        send_item(16'sd256, 1'b0, 1'b0);
        send_item(16'sd256, 1'b0, 1'b0);
        send_item(16'sd256, 1'b0, 1'b0);
        send_item(16'sd0, 1'b0, 1'b1);
        send_item(-16'sd32768, 1'b0, 1'b0);
        send_item(-16'sd32767, 1'b0, 1'b1);
    endtask

    task automatic test_masking();
        send_item(16'sd500, 1'b1, 1'b0);
        send_item(-16'sd300, 1'b0, 1'b0);
        send_item(16'sh7FFF, 1'b1, 1'b1);
        send_item(16'sd12, 1'b1, 1'b0);
        send_item(-16'sd32768, 1'b1, 1'b0);
        send_item(16'sh7FFF, 1'b1, 1'b1);
        send_item(16'sd0, 1'b1, 1'b1);
    endtask

    task automatic test_overlong_row();
        for (int i = 0; i < ROW_LEN + 3; i++)
            send_item(16'($urandom_range(0, 2047)) - 16'sd1024, 1'($urandom_range(0, 4) == 0),
                      i == ROW_LEN + 2);
    endtask

    task automatic test_random_rows(int items);
        int len;
        int left;
        int mode;
        logic signed [15:0] base;
        logic signed [15:0] s;
        left = items;
        while (left > 0)
        begin
            len  = $urandom_range(1, 12);
            mode = $urandom_range(0, 9);
            base = 16'($urandom);
            for (int i = 0; i < len; i++)
            begin
                if (mode < 6)
                    s = base + 16'($urandom_range(0, 1536)) - 16'sd768;
                else
                    s = 16'($urandom);
                send_item(s, mode == 9 ? 1'b1 : 1'($urandom_range(0, 3) == 0), i == len - 1);
            end
            left -= len;
        end
    endtask

    initial
    begin
        build_lut();
        quiet         = 1'b0;
        n_err         = 0;
        n_items       = 0;
        n_rows        = 0;
        n_results     = 0;
        row_fill      = 0;
        row_max       = '0;
        row_seen      = 1'b0;
        row_drop      = 1'b0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.score   <= '0;
        in_ch.masked  <= 1'b0;
        in_ch.row_end <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_rows();
        test_masking();
        wait_drained();
        test_overlong_row();
        test_random_rows(16);
        wait_drained();
        quiet = 1'b1;
        test_random_rows(16);
        wait_drained();
        repeat (800) @(posedge clk);

        $display("Covered %0d rows, %0d input transactions, %0d output transactions,",
                 n_rows, n_items, n_results);
        $display("including masked, fully masked and overlong rows; %0d mismatches.", n_err);
        if (n_err == 0 && probs_due.size() == 0)
            $display("** masked_softmax_row_core: PASSED **");
        else
            $display("** masked_softmax_row_core: FAILED **");
        $finish;
    end
endmodule
